>>> hdl/binary_grid_gap_closing_defines.svh
// -----------------------------------------------------------------------------
// Binary grid gap closing: assertion macros
// Shared concurrent assertion forms for the block's modules.
// -----------------------------------------------------------------------------
`ifndef BINARY_GRID_GAP_CLOSING_DEFINES_SVH
`define BINARY_GRID_GAP_CLOSING_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BGC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BGC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/bgc_pkg.sv
// -----------------------------------------------------------------------------
// bgc_pkg
// Types and constants shared by the binary grid gap closing modules.
// -----------------------------------------------------------------------------
`default_nettype none

package bgc_pkg;

    // Common width for unsigned compares of coordinates, quotients and counts.
    localparam int CMP_W      = 12;
    localparam int QUERY_W    = 12;
    localparam int DIV_STEPS  = 12;
    localparam int DIV_CNT_W  = 4;
    localparam int GRID_W     = 7;
    localparam int CELL_IDX_W = 6;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;

    localparam logic [GRID_W-1:0]  GRID_WIDTH_RST  = 7'd64;
    localparam logic [GRID_W-1:0]  GRID_HEIGHT_RST = 7'd64;
    localparam logic [QUERY_W-1:0] CELL_WIDTH_RST  = 12'd8;
    localparam logic [QUERY_W-1:0] CELL_HEIGHT_RST = 12'd8;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_CLOSE = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_CELL_WIDTH  = 2'd2,
        REG_CELL_HEIGHT = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_DRAIN,
        ST_FLUSH,
        ST_DIV,
        ST_READ,
        ST_FIN,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_OUT_NOW,
        RES_HOLD,
        RES_OUT_HELD
    } res_op_t;

    typedef struct packed {
        logic    load_wr;
        logic    sweep_clr;
        logic    sweep_step;
        logic    div_start;
        logic    q_read;
        logic    res_query;
        res_op_t res_op;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic div_done;
    } status_t;

    typedef struct packed {
        logic out_of_grid;
        logic inside_field;
    } res_t;

endpackage

`default_nettype wire

>>> hdl/binary_grid_gap_closing.sv
// -----------------------------------------------------------------------------
// binary_grid_gap_closing
// Top level: bit grid with cell loads, row-then-column gap closing and queries.
// -----------------------------------------------------------------------------
// Usage. Commands arrive as beats on the s_ channel; each produces exactly one
// result beat on the m_ channel, in order. A load writes one cell of the grid,
// a close fills gaps of one or two clear cells bounded by set cells, first
// along every row in use and then down every column, and a query maps a pixel
// to its cell and returns the cell bit or an out-of-grid flag. A separate
// configuration channel (cfg_) sets the grid size and the cell size in pixels;
// the user must write it only while the block is idle, which the block does
// not enforce; it is always ready. Loads and the unused command are answered
// from the idle state and, while the output is free, can be taken one per
// cycle. A query runs the 12-step bit-serial divider followed by one grid read.
// A close sweep reads one grid row per cycle from the row memory. No new
// command is taken while a query or close is in progress.
// Reset. aresetn is synchronous and active low; the grid reads as all clear
// after reset through per-row valid flags, so no clearing pass is needed.
// Stalls. A finished result sits in the output register; while the receiver
// holds m_tready low the next result is parked and no further command is taken.
// -----------------------------------------------------------------------------
`default_nettype none

module binary_grid_gap_closing #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Command channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [1:0] func, [7:2] cell_col, [13:8] cell_row, [14] cell_is_field,
    // [26:15] query_x, [38:27] query_y, [39] zero
    input  wire logic [39:0] s_tdata,
    // Result channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] inside_field, [1] out_of_grid, [7:2] zero
    output logic [7:0]       m_tdata,
    // Configuration write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [11:0] cfg_data
);

    bgc_pkg::cmd_t    cmd;
    bgc_pkg::status_t status;
    bgc_pkg::res_t    out_res;
    logic             cfg_wr;

    // Configuration is taken every cycle; writes land in the datapath.
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    bgc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_func   (s_tdata[1:0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    bgc_dpath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cell_col      (s_tdata[7:2]),
        .cell_row      (s_tdata[13:8]),
        .cell_is_field (s_tdata[14]),
        .query_x       (s_tdata[26:15]),
        .query_y       (s_tdata[38:27]),
        .cfg_valid     (cfg_wr),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_res       (out_res)
    );

    // The result word is padded with zeros up to a whole byte.
    assign m_tdata = {6'd0, out_res.out_of_grid, out_res.inside_field};

endmodule

`default_nettype wire

>>> hdl/bgc_ram.sv
// -----------------------------------------------------------------------------
// bgc_ram
// Generic simple dual-port RAM with per-bit write mask and registered read.
// -----------------------------------------------------------------------------
`default_nettype none

module bgc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [WIDTH-1:0]         wmask,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        for (int i = 0; i < WIDTH; i++) begin
            if (we && wmask[i]) begin
                mem[waddr][i] <= wdata[i];
            end
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/bgc_div.sv
// -----------------------------------------------------------------------------
// bgc_div
// Restoring divider, one quotient bit per cycle, for pixel-to-cell mapping.
// -----------------------------------------------------------------------------
`default_nettype none

module bgc_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [bgc_pkg::QUERY_W-1:0] dividend,
    input  wire logic [bgc_pkg::QUERY_W-1:0] divisor,
    output logic      [bgc_pkg::QUERY_W-1:0] quotient,
    output logic                             done
);

    localparam int QW = bgc_pkg::QUERY_W;

    logic                            busy_reg;
    logic                            done_reg;
    logic [bgc_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [QW-1:0]                   dvd_reg;
    logic [QW-1:0]                   dsr_reg;
    logic [QW-1:0]                   rem_reg;
    logic [QW:0]                     shifted;
    logic [QW:0]                     diff;
    logic                            ge;
    logic [QW-1:0]                   rem_next;

    // A zero divisor yields an all-ones quotient, which lies beyond any grid.
    always_comb begin
        shifted  = {rem_reg, dvd_reg[QW-1]};
        diff     = shifted - {1'b0, dsr_reg};
        ge       = (shifted >= {1'b0, dsr_reg});
        rem_next = ge ? diff[QW-1:0] : shifted[QW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= bgc_pkg::DIV_CNT_W'(bgc_pkg::DIV_STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - bgc_pkg::DIV_CNT_W'(1);
                if (cnt_reg == bgc_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[QW-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

>>> hdl/bgc_dpath.sv
// -----------------------------------------------------------------------------
// bgc_dpath
// Grid store, configuration registers, close sweep pipeline and query path.
// -----------------------------------------------------------------------------
`default_nettype none

module bgc_dpath #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire bgc_pkg::cmd_t                  cmd,
    output bgc_pkg::status_t                    status,
    input  wire logic [bgc_pkg::CELL_IDX_W-1:0] cell_col,
    input  wire logic [bgc_pkg::CELL_IDX_W-1:0] cell_row,
    input  wire logic                           cell_is_field,
    input  wire logic [bgc_pkg::QUERY_W-1:0]    query_x,
    input  wire logic [bgc_pkg::QUERY_W-1:0]    query_y,
    input  wire logic                           cfg_valid,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [bgc_pkg::QUERY_W-1:0]    cfg_data,
    output bgc_pkg::res_t                       out_res
);

    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int NCW   = $clog2(MAX_COLS + 1);
    localparam int NRW   = $clog2(MAX_ROWS + 1);
    localparam int KW    = $clog2(MAX_ROWS + 3);
    localparam int CMPW  = bgc_pkg::CMP_W;

    // Configuration registers.
    logic [bgc_pkg::GRID_W-1:0]  grid_width_reg;
    logic [bgc_pkg::GRID_W-1:0]  grid_height_reg;
    logic [bgc_pkg::QUERY_W-1:0] cell_width_reg;
    logic [bgc_pkg::QUERY_W-1:0] cell_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= bgc_pkg::GRID_WIDTH_RST;
            grid_height_reg <= bgc_pkg::GRID_HEIGHT_RST;
            cell_width_reg  <= bgc_pkg::CELL_WIDTH_RST;
            cell_height_reg <= bgc_pkg::CELL_HEIGHT_RST;
        end else if (cfg_valid) begin
            unique case (bgc_pkg::reg_idx_t'(cfg_index))
                bgc_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[bgc_pkg::GRID_W-1:0];
                bgc_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_data[bgc_pkg::GRID_W-1:0];
                bgc_pkg::REG_CELL_WIDTH:  cell_width_reg  <= cfg_data;
                bgc_pkg::REG_CELL_HEIGHT: cell_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Grid size in use, clamped to the store.
    logic [NCW-1:0]      ncols;
    logic [NRW-1:0]      nrows;
    logic [CMPW-1:0]     ncols_c;
    logic [CMPW-1:0]     nrows_c;
    logic [MAX_COLS-1:0] use_mask;

    always_comb begin
        ncols = (CMPW'(grid_width_reg) >= CMPW'(MAX_COLS)) ? NCW'(MAX_COLS)
                                                           : NCW'(grid_width_reg);
        nrows = (CMPW'(grid_height_reg) >= CMPW'(MAX_ROWS)) ? NRW'(MAX_ROWS)
                                                            : NRW'(grid_height_reg);
        ncols_c = CMPW'(ncols);
        nrows_c = CMPW'(nrows);
        for (int c = 0; c < MAX_COLS; c++) begin
            use_mask[c] = (CMPW'(c) < ncols_c);
        end
    end

    // Grid store: one memory word per row, plus a valid flag per row so that
    // rows never written read as cleared.
    logic                ram_we;
    logic [RW-1:0]       ram_waddr;
    logic [MAX_COLS-1:0] ram_wdata;
    logic [MAX_COLS-1:0] ram_wmask;
    logic                ram_re;
    logic [RW-1:0]       ram_raddr;
    logic [MAX_COLS-1:0] ram_rdata;
    logic [MAX_ROWS-1:0] row_valid_reg;

    bgc_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_grid_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .wmask (ram_wmask),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (ram_we) begin
            row_valid_reg[ram_waddr] <= 1'b1;
        end
    end

    // Query divide: both coordinates in parallel.
    logic [bgc_pkg::QUERY_W-1:0] quo_x;
    logic [bgc_pkg::QUERY_W-1:0] quo_y;
    logic                        done_x;
    logic                        done_y;

    bgc_div u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (query_x),
        .divisor  (cell_width_reg),
        .quotient (quo_x),
        .done     (done_x)
    );

    bgc_div u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (query_y),
        .divisor  (cell_height_reg),
        .quotient (quo_y),
        .done     (done_y)
    );

    logic          q_hit;
    logic          q_hit_reg;
    logic          q_valid_reg;
    logic [CW-1:0] q_col_reg;

    assign q_hit = (CMPW'(quo_x) < ncols_c) && (CMPW'(quo_y) < nrows_c);

    always_ff @(posedge aclk) begin
        if (cmd.q_read) begin
            q_hit_reg   <= q_hit;
            q_valid_reg <= q_hit && row_valid_reg[quo_y[RW-1:0]];
            q_col_reg   <= quo_x[CW-1:0];
        end
    end

    // Load addressing.
    logic [CMPW-1:0]     ld_col_ext;
    logic [CMPW-1:0]     ld_row_ext;
    logic                ld_hit;
    logic [MAX_COLS-1:0] ld_onehot;

    always_comb begin
        ld_col_ext = CMPW'(cell_col);
        ld_row_ext = CMPW'(cell_row);
        ld_hit     = (ld_col_ext < ncols_c) && (ld_row_ext < nrows_c);
        ld_onehot  = {{(MAX_COLS-1){1'b0}}, 1'b1} << ld_col_ext[CW-1:0];
    end

    // Close sweep. Row k is read, closed along the row, and pushed into a
    // window of five rows; row k-2 is then closed along the column and
    // written back from the write register in the next cycle.
    logic [KW-1:0]       k_reg;
    logic                k_in;
    logic                s1_act_reg;
    logic                s1_ok_reg;
    logic [KW-1:0]       s1_k_reg;
    logic [MAX_COLS-1:0] win_reg [4];
    logic [MAX_COLS-1:0] row_in;
    logic [MAX_COLS-1:0] rm;
    logic [MAX_COLS-1:0] l1, l2, r1, r2;
    logic [MAX_COLS-1:0] rc_new;
    logic [MAX_COLS-1:0] cc, cu1, cu2, cd1, cd2;
    logic [MAX_COLS-1:0] col_out;
    logic [KW-1:0]       p_idx;
    logic                wr_en_reg;
    logic [RW-1:0]       wr_addr_reg;
    logic [MAX_COLS-1:0] wr_row_reg;

    assign k_in              = (CMPW'(k_reg) < nrows_c);
    assign status.sweep_last = (CMPW'(k_reg) == nrows_c + CMPW'(1));
    assign status.div_done   = done_x & done_y;

    always_comb begin
        row_in = s1_ok_reg ? ram_rdata : '0;
        // A clear cell is filled when the set cells around it leave a gap of
        // one or two cells.
        rm     = row_in & use_mask;
        l1     = rm << 1;
        l2     = rm << 2;
        r1     = rm >> 1;
        r2     = rm >> 2;
        rc_new = row_in | (~rm & use_mask &
                 ((l1 & r1) | (l1 & ~r1 & r2) | (l2 & ~l1 & r1)));
        cu2    = win_reg[3] & use_mask;
        cu1    = win_reg[2] & use_mask;
        cc     = win_reg[1] & use_mask;
        cd1    = win_reg[0] & use_mask;
        cd2    = rc_new & use_mask;
        col_out = win_reg[1] | (~cc & use_mask &
                  ((cu1 & cd1) | (cu1 & ~cd1 & cd2) | (cu2 & ~cu1 & cd1)));
        p_idx  = s1_k_reg - KW'(2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_act_reg <= 1'b0;
            wr_en_reg  <= 1'b0;
        end else begin
            s1_act_reg <= cmd.sweep_step;
            wr_en_reg  <= s1_act_reg && (s1_k_reg >= KW'(2));
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sweep_clr) begin
            k_reg <= '0;
        end else if (cmd.sweep_step) begin
            k_reg <= k_reg + KW'(1);
        end
        s1_ok_reg   <= cmd.sweep_step && k_in && row_valid_reg[k_reg[RW-1:0]];
        s1_k_reg    <= k_reg;
        wr_addr_reg <= p_idx[RW-1:0];
        wr_row_reg  <= col_out;
        if (cmd.sweep_clr) begin
            for (int i = 0; i < 4; i++) begin
                win_reg[i] <= '0;
            end
        end else if (s1_act_reg) begin
            win_reg[0] <= rc_new;
            win_reg[1] <= win_reg[0];
            win_reg[2] <= win_reg[1];
            win_reg[3] <= win_reg[2];
        end
    end

    // Memory port selection.
    always_comb begin
        ram_re    = (cmd.sweep_step && k_in) || (cmd.q_read && q_hit);
        ram_raddr = cmd.sweep_step ? k_reg[RW-1:0] : quo_y[RW-1:0];
        ram_we    = 1'b0;
        ram_waddr = wr_addr_reg;
        ram_wdata = wr_row_reg;
        ram_wmask = '1;
        if (wr_en_reg) begin
            ram_we = 1'b1;
        end else if (cmd.load_wr && ld_hit) begin
            ram_we    = 1'b1;
            ram_waddr = ld_row_ext[RW-1:0];
            ram_wdata = cell_is_field ? ld_onehot : '0;
            ram_wmask = row_valid_reg[ld_row_ext[RW-1:0]] ? ld_onehot : '1;
        end
    end

    // Result registers.
    bgc_pkg::res_t res_now;
    bgc_pkg::res_t held_reg;
    bgc_pkg::res_t out_reg;

    always_comb begin
        res_now.inside_field = cmd.res_query & q_hit_reg & q_valid_reg & ram_rdata[q_col_reg];
        res_now.out_of_grid  = cmd.res_query & ~q_hit_reg;
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.res_op)
            bgc_pkg::RES_OUT_NOW:  out_reg  <= res_now;
            bgc_pkg::RES_HOLD:     held_reg <= res_now;
            bgc_pkg::RES_OUT_HELD: out_reg  <= held_reg;
            default: ;
        endcase
    end

    assign out_res = out_reg;

endmodule

`default_nettype wire

>>> hdl/bgc_ctrl.sv
// -----------------------------------------------------------------------------
// bgc_ctrl
// Operation sequencer and result handshake for the grid gap closing block.
// -----------------------------------------------------------------------------
`default_nettype none

`include "binary_grid_gap_closing_defines.svh"

module bgc_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [1:0]              s_func,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output bgc_pkg::cmd_t                cmd,
    input  wire bgc_pkg::status_t        status
);

    bgc_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            out_free;
    logic            finish;

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bgc_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        finish       = 1'b0;
        s_tready     = 1'b0;
        unique case (state_reg)
            bgc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (bgc_pkg::func_t'(s_func))
                        bgc_pkg::FUNC_LOAD: begin
                            cmd.load_wr = 1'b1;
                            finish      = 1'b1;
                        end
                        bgc_pkg::FUNC_CLOSE: begin
                            cmd.sweep_clr = 1'b1;
                            state_next    = bgc_pkg::ST_CLOSE;
                        end
                        bgc_pkg::FUNC_QUERY: begin
                            cmd.div_start = 1'b1;
                            state_next    = bgc_pkg::ST_DIV;
                        end
                        bgc_pkg::FUNC_NOP: begin
                            finish = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            bgc_pkg::ST_CLOSE: begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last) begin
                    state_next = bgc_pkg::ST_DRAIN;
                end
            end
            bgc_pkg::ST_DRAIN: begin
                state_next = bgc_pkg::ST_FLUSH;
            end
            bgc_pkg::ST_FLUSH: begin
                finish = 1'b1;
            end
            bgc_pkg::ST_DIV: begin
                if (status.div_done) begin
                    state_next = bgc_pkg::ST_READ;
                end
            end
            bgc_pkg::ST_READ: begin
                cmd.q_read = 1'b1;
                state_next = bgc_pkg::ST_FIN;
            end
            bgc_pkg::ST_FIN: begin
                cmd.res_query = 1'b1;
                finish        = 1'b1;
            end
            bgc_pkg::ST_RESP: begin
                if (out_free) begin
                    cmd.res_op   = bgc_pkg::RES_OUT_HELD;
                    m_valid_next = 1'b1;
                    state_next   = bgc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bgc_pkg::ST_IDLE;
            end
        endcase

        // Hand the result to the output register, or park it while the
        // receiver still holds the previous one.
        if (finish) begin
            if (out_free) begin
                cmd.res_op   = bgc_pkg::RES_OUT_NOW;
                m_valid_next = 1'b1;
                state_next   = bgc_pkg::ST_IDLE;
            end else begin
                cmd.res_op = bgc_pkg::RES_HOLD;
                state_next = bgc_pkg::ST_RESP;
            end
        end
    end

    assign m_tvalid = m_valid_reg;

    `BGC_ASSERT_IMP(a_resp_has_busy_out, aclk, aresetn, state_reg == bgc_pkg::ST_RESP, m_valid_reg, "parked result without a pending output beat")
    `BGC_ASSERT_IMP(a_div_done_in_div, aclk, aresetn, status.div_done, state_reg == bgc_pkg::ST_DIV, "divider finished outside the divide wait")
    `BGC_ASSERT_IMP(a_no_overwrite, aclk, aresetn, m_valid_reg && !m_tready, cmd.res_op != bgc_pkg::RES_OUT_NOW && cmd.res_op != bgc_pkg::RES_OUT_HELD, "output register overwritten while stalled")

endmodule

`default_nettype wire

>>> sim/bgc_grid_checker.sv
// -----------------------------------------------------------------------------
// bgc_grid_checker
// Watches the command, result and configuration channels of the gap closing
// block. It keeps its own copy of the cell grid and the registers, and works
// out the expected result of every accepted command. Each result beat is
// compared field by field with the oldest expected result.
// -----------------------------------------------------------------------------
module bgc_grid_checker
    import bgc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [11:0]          cfg_data,
    output int                        n_pending,
    output int                        n_errors,
    output int                        n_outside
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_COLS     = 64;
    localparam int MAP_ROWS     = 64;
    // Runs shorter than this many clear cells are filled by a close.
    localparam int GAP_FILL_MAX = 3;

    logic [MAP_COLS-1:0] field_map [MAP_ROWS];
    logic [GRID_W-1:0]   grid_cols_reg;
    logic [GRID_W-1:0]   grid_rows_reg;
    logic [QUERY_W-1:0]  cell_w_reg;
    logic [QUERY_W-1:0]  cell_h_reg;
    res_t                expected_res [$];

    // Every row scan starts fresh, so clear cells ahead of the first set cell stay clear.
    task automatic fill_row_gaps(input int ncols, input int nrows);
        int  last;
        bit  seen;
        for (int r = 0; r < nrows; r++) begin
            seen = 1'b0;
            last = 0;
            for (int c = 0; c < ncols; c++) begin
                if (field_map[r][c]) begin
                    if (seen && (c - last - 1) < GAP_FILL_MAX) begin
                        for (int z = last + 1; z < c; z++) field_map[r][z] = 1'b1;
                    end
                    seen = 1'b1;
                    last = c;
                end
            end
        end
    endtask

    task automatic fill_col_gaps(input int ncols, input int nrows);
        int  last;
        bit  seen;
        for (int c = 0; c < ncols; c++) begin
            seen = 1'b0;
            last = 0;
            for (int r = 0; r < nrows; r++) begin
                if (field_map[r][c]) begin
                    if (seen && (r - last - 1) < GAP_FILL_MAX) begin
                        for (int z = last + 1; z < r; z++) field_map[z][c] = 1'b1;
                    end
                    seen = 1'b1;
                    last = r;
                end
            end
        end
    endtask

    task automatic predict_result(input logic [S_TDATA_W-1:0] cmd, output res_t res);
        func_t                 op;
        logic [CELL_IDX_W-1:0] col;
        logic [CELL_IDX_W-1:0] row;
        logic                  cell_bit;
        logic [QUERY_W-1:0]    qx;
        logic [QUERY_W-1:0]    qy;
        int                    ncols;
        int                    nrows;
        int                    cx;
        int                    cy;
        op       = func_t'(cmd[1:0]);
        col      = cmd[7:2];
        row      = cmd[13:8];
        cell_bit = cmd[14];
        qx       = cmd[26:15];
        qy       = cmd[38:27];
        ncols    = (grid_cols_reg > MAP_COLS) ? MAP_COLS : int'(grid_cols_reg);
        nrows    = (grid_rows_reg > MAP_ROWS) ? MAP_ROWS : int'(grid_rows_reg);
        res      = '0;
        case (op)
            FUNC_LOAD: begin
                if (col < ncols && row < nrows) field_map[row][col] = cell_bit;
            end
            FUNC_CLOSE: begin
                fill_row_gaps(ncols, nrows);
                fill_col_gaps(ncols, nrows);
            end
            FUNC_QUERY: begin
                if (cell_w_reg == '0 || cell_h_reg == '0) begin
                    res.out_of_grid = 1'b1;
                end else begin
                    cx = qx / cell_w_reg;
                    cy = qy / cell_h_reg;
                    if (cx < ncols && cy < nrows) res.inside_field = field_map[cy][cx];
                    else res.out_of_grid = 1'b1;
                end
                if (res.out_of_grid) n_outside++;
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (!aresetn) begin
            for (int r = 0; r < MAP_ROWS; r++) field_map[r] = '0;
            grid_cols_reg = GRID_WIDTH_RST;
            grid_rows_reg = GRID_HEIGHT_RST;
            cell_w_reg    = CELL_WIDTH_RST;
            cell_h_reg    = CELL_HEIGHT_RST;
            expected_res.delete();
            n_pending = 0;
            n_errors  = 0;
            n_outside = 0;
        end else begin
            // A result beat can only belong to a command taken at an earlier edge.
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata[1:0]);
                if (expected_res.size() == 0) begin
                    $error("result beat with no command outstanding: m_tdata=%0h", m_tdata);
                    n_errors++;
                end else begin
                    want = expected_res.pop_front();
                    if (got.inside_field !== want.inside_field) begin
                        $error("inside_field mismatch: expected %0d, actual %0d",
                               want.inside_field, got.inside_field);
                        n_errors++;
                    end
                    if (got.out_of_grid !== want.out_of_grid) begin
                        $error("out_of_grid mismatch: expected %0d, actual %0d",
                               want.out_of_grid, got.out_of_grid);
                        n_errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (reg_idx_t'(cfg_index))
                    REG_GRID_WIDTH:  grid_cols_reg = cfg_data[GRID_W-1:0];
                    REG_GRID_HEIGHT: grid_rows_reg = cfg_data[GRID_W-1:0];
                    REG_CELL_WIDTH:  cell_w_reg    = cfg_data;
                    REG_CELL_HEIGHT: cell_h_reg    = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_result(s_tdata, want);
                expected_res.push_back(want);
            end
            n_pending = expected_res.size();
        end
    end

endmodule

>>> sim/tb_binary_grid_gap_closing.sv
// -----------------------------------------------------------------------------
// tb_binary_grid_gap_closing
// Drives loads, closes, queries and the unused command into the gap closing
// block under a series of grid and cell size settings, with random idle
// cycles on the command side and random back-pressure on the result side.
// A checker module beside the block predicts and compares every result beat.
// -----------------------------------------------------------------------------
module tb_binary_grid_gap_closing;
    timeunit 1ns;
    timeprecision 1ps;

    import bgc_pkg::*;

    // Number of register settings visited by the random part, and the
    // command beats sent under each of them.
    localparam int N_SETTINGS  = 9;
    localparam int PHASE_ITEMS = 195;
    // Loads and queries are aimed at a window of at most this many cells per side,
    // so that the grid fills densely enough for a close to find gaps.
    localparam int WIN_MAX     = 8;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    reg_idx_t             cfg_index = REG_GRID_WIDTH;
    logic [11:0]          cfg_data  = '0;

    int n_pending;
    int n_errors;
    int n_outside;
    int n_loads;
    int n_closes;
    int n_queries;
    int n_noops;
    int n_settings;

    // The sender flips between stretches of back-to-back beats and stretches
    // with random gaps; the receiver does the same with its ready.
    bit steady_send  = 1'b1;
    bit steady_drain = 1'b0;
    int stall_left   = 0;

    always #10 aclk = ~aclk;

    binary_grid_gap_closing u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bgc_grid_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .n_pending (n_pending),
        .n_errors  (n_errors),
        .n_outside (n_outside)
    );

    // Result side back-pressure. Most stalls are short, a few are long,
    // and now and then the receiver stays ready for a long stretch.
    always @(posedge aclk) begin
        logic ready_next;
        if (steady_drain) begin
            ready_next = 1'b1;
        end else if (stall_left > 0) begin
            ready_next = 1'b0;
            stall_left--;
        end else begin
            ready_next = 1'b1;
            if ($urandom_range(0, 99) < 25) begin
                stall_left = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3)
                                                        : $urandom_range(10, 40);
            end
        end
        if ($urandom_range(0, 79) == 0) steady_drain = !steady_drain;
        m_tready <= ready_next;
    end

    // Sends one command beat and waits for it to be taken. The valid is left
    // high after the beat so that a following beat can go out on the next edge;
    // it only drops when a gap is inserted or the phase ends.
    task automatic send_cmd(input func_t op, input int col, input int row,
                            input int cell_bit, input int qx, input int qy);
        int gap;
        case (op)
            FUNC_LOAD:  n_loads++;
            FUNC_CLOSE: n_closes++;
            FUNC_QUERY: n_queries++;
            default:    n_noops++;
        endcase
        s_tdata  <= {1'b0, qy[11:0], qx[11:0], cell_bit[0], row[5:0], col[5:0], op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (!steady_send && $urandom_range(0, 99) >= 55) begin
            gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        if ($urandom_range(0, 49) == 0) steady_send = !steady_send;
    endtask

    // Writes one configuration register; the valid stays high for a following write.
    task automatic cfg_beat(input reg_idx_t idx, input int value);
        cfg_index <= idx;
        cfg_data  <= value[11:0];
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Drops the command valid and waits until every expected result has arrived.
    // The first edge lets the checker record the last accepted command beat.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
    endtask

    // Picks a cell index: mostly inside the hot window, sometimes anywhere in
    // the grid in use, and sometimes anywhere the field allows.
    function automatic int pick_cell(input int base, input int span_win, input int span_grid);
        int k;
        k = $urandom_range(0, 99);
        if (k < 70) return base + $urandom_range(0, span_win - 1);
        if (k < 85) return $urandom_range(0, span_grid - 1);
        return $urandom_range(0, 63);
    endfunction

    // Picks a pixel coordinate for a query in the same spirit, with a margin of
    // one cell past the grid edge so that the out-of-grid boundary is hit.
    function automatic int pick_pixel(input int base, input int span_win, input int span_grid,
                                      input int cell_px);
        int k;
        int lim;
        k = $urandom_range(0, 99);
        if (cell_px == 0 || k >= 85) return $urandom_range(0, 4095);
        if (k < 60) begin
            return ((base + $urandom_range(0, span_win - 1)) * cell_px
                    + $urandom_range(0, cell_px - 1)) & 12'hFFF;
        end
        lim = cell_px * (span_grid + 1);
        return $urandom_range(0, (lim > 4095) ? 4095 : lim);
    endfunction

    initial begin
        int gw;
        int gh;
        int cw;
        int ch;
        int span_c;
        int span_r;
        int win_c0;
        int win_r0;
        int win_nc;
        int win_nr;
        int k;
        n_loads    = 0;
        n_closes   = 0;
        n_queries  = 0;
        n_noops    = 0;
        n_settings = 0;

        // Reset is held from the start and never asserted again.
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset settings: a 64 by 64 grid of 8 pixel cells.
        // The grid must read as clear straight after reset.
        send_cmd(FUNC_QUERY, 0, 0, 0, 0, 0);
        // Far corner of the grid, then one pixel past it in x, then the largest coordinates.
        send_cmd(FUNC_QUERY, 0, 0, 0, 511, 511);
        send_cmd(FUNC_QUERY, 0, 0, 0, 512, 0);
        send_cmd(FUNC_QUERY, 63, 63, 1, 4095, 4095);
        // Row 0 gets a gap of one, a gap of two and a gap of three; only the
        // first two are short enough to be closed.
        send_cmd(FUNC_LOAD, 0, 0, 1, 0, 0);
        send_cmd(FUNC_LOAD, 2, 0, 1, 0, 0);
        send_cmd(FUNC_LOAD, 5, 0, 1, 0, 0);
        send_cmd(FUNC_LOAD, 9, 0, 1, 0, 0);
        send_cmd(FUNC_LOAD, 63, 63, 1, 4095, 4095);
        // Column 1 gets a gap of one and a gap of two down the rows.
        send_cmd(FUNC_LOAD, 1, 10, 1, 0, 0);
        send_cmd(FUNC_LOAD, 1, 12, 1, 0, 0);
        send_cmd(FUNC_LOAD, 1, 15, 1, 0, 0);
        // Clearing a cell that was set, and setting one more cell.
        send_cmd(FUNC_LOAD, 63, 63, 0, 0, 0);
        send_cmd(FUNC_LOAD, 40, 20, 1, 0, 0);
        // The unused command with every field bit set must leave the grid alone.
        send_cmd(FUNC_NOP, 63, 63, 1, 4095, 4095);
        send_cmd(FUNC_CLOSE, 0, 0, 0, 0, 0);
        send_cmd(FUNC_QUERY, 0, 0, 0, 8, 0);
        send_cmd(FUNC_QUERY, 0, 0, 0, 24, 0);
        send_cmd(FUNC_QUERY, 0, 0, 0, 48, 0);
        send_cmd(FUNC_QUERY, 0, 0, 0, 8, 88);
        send_cmd(FUNC_QUERY, 0, 0, 0, 15, 111);
        send_cmd(FUNC_QUERY, 0, 0, 0, 0, 0);
        send_cmd(FUNC_QUERY, 0, 0, 0, 504, 504);

        // Random part: one block of commands per register setting.
        for (int p = 0; p < N_SETTINGS; p++) begin
            case (p)
                0: begin gw = 8;   gh = 8;   cw = 8;    ch = 8;    end
                // Largest grid with the smallest cells.
                1: begin gw = 64;  gh = 64;  cw = 1;    ch = 1;    end
                // Single cell with the largest cells.
                2: begin gw = 1;   gh = 1;   cw = 4095; ch = 4095; end
                3: begin gw = 5;   gh = 12;  cw = 3;    ch = 7;    end
                // Grid sizes beyond the store are clamped to it.
                4: begin gw = 127; gh = 100; cw = 63;   ch = 64;   end
                // A zero grid dimension leaves no cells in use; a zero cell
                // size flags every query.
                5: begin gw = 0;   gh = 10;  cw = 0;    ch = 5;    end
                6: begin gw = 10;  gh = 0;   cw = 7;    ch = 0;    end
                7: begin
                    gw = $urandom_range(1, 16);
                    gh = $urandom_range(1, 16);
                    cw = $urandom_range(1, 600);
                    ch = $urandom_range(1, 600);
                end
                default: begin gw = 64; gh = 4; cw = 2048; ch = 1; end
            endcase

            // Registers are only written once the block has delivered every result.
            settle();
            cfg_beat(REG_GRID_WIDTH, gw);
            cfg_beat(REG_GRID_HEIGHT, gh);
            cfg_beat(REG_CELL_WIDTH, cw);
            cfg_beat(REG_CELL_HEIGHT, ch);
            cfg_valid <= 1'b0;
            n_settings++;

            span_c = (gw == 0) ? 1 : ((gw > 64) ? 64 : gw);
            span_r = (gh == 0) ? 1 : ((gh > 64) ? 64 : gh);
            win_nc = (span_c < WIN_MAX) ? span_c : WIN_MAX;
            win_nr = (span_r < WIN_MAX) ? span_r : WIN_MAX;
            win_c0 = $urandom_range(0, span_c - win_nc);
            win_r0 = $urandom_range(0, span_r - win_nr);

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // Loads dominate so the window fills up, closes come often enough to
                // work on partly filled grids, and queries read back what was built.
                k = $urandom_range(0, 99);
                if (k < 52) begin
                    send_cmd(FUNC_LOAD,
                             pick_cell(win_c0, win_nc, span_c),
                             pick_cell(win_r0, win_nr, span_r),
                             ($urandom_range(0, 99) < 65) ? 1 : 0,
                             $urandom_range(0, 4095), $urandom_range(0, 4095));
                end else if (k < 62) begin
                    send_cmd(FUNC_CLOSE, $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 1), $urandom_range(0, 4095),
                             $urandom_range(0, 4095));
                end else if (k < 97) begin
                    send_cmd(FUNC_QUERY, $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 1),
                             pick_pixel(win_c0, win_nc, span_c, cw),
                             pick_pixel(win_r0, win_nr, span_r, ch));
                end else begin
                    send_cmd(FUNC_NOP, $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 1), $urandom_range(0, 4095),
                             $urandom_range(0, 4095));
                end
            end
        end

        // Wait for the last results, then watch a while longer for stray beats.
        settle();
        repeat (80) @(posedge aclk);

        $display("Run covered %0d loads, %0d closes, %0d queries and %0d unused commands",
                 n_loads, n_closes, n_queries, n_noops);
        $display("under %0d register settings; %0d queries were flagged outside the grid.",
                 n_settings + 1, n_outside);
        if (n_errors == 0 && n_pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of full-height closes and long stalls.
    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule
